@@ rtl/core/link_quality_ping_window_core_assert.svh @@
// Assertion macros shared by the link quality checker.
// Each macro places one labeled concurrent assertion on the given clock.
`ifndef LINK_QUALITY_PING_WINDOW_CORE_ASSERT_SVH
`define LINK_QUALITY_PING_WINDOW_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LQPW_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LQPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define LQPW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lqpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqpw_pkg
// Types and constants of the sliding-window link quality estimator.
// ----------------------------------------------------------------------------
package lqpw_pkg;

    localparam int TIME_W        = 32;
    localparam int BI_W          = 8;
    localparam int LQ_W          = 5;
    localparam int DIV_W         = TIME_W + 1;
    localparam int STEP_W        = $clog2(DIV_W);
    localparam int TDATA_IN_W    = 32;
    localparam int TDATA_OUT_W   = 8;
    localparam int SLOTS_DEFAULT = 16;

    localparam logic [BI_W-1:0] BI_RESET = 8'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_DIV,
        ST_ROT,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/link_quality_ping_window_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// link_quality_ping_window_core
// Ping-window link quality estimator for one neighbor.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per event. tuser[0] is the mode (0 = a beacon was
//   received, then query; 1 = query only), tdata[31:0] the current time in
//   seconds. Master stream: one beat per input beat, tdata[4:0] holds the
//   number of hit slots in the window, upper bits zero.
//   cfg_wr_en/cfg_wr_data write the beacon interval (0 acts as 1); write it
//   only while no beat is in flight.
//   The 33-step restoring divider rounds elapsed time to whole intervals;
//   on a ping that advances the window, the ring is then rotated by the
//   number of elapsed intervals modulo WINDOW_SLOTS, and a walk visits one
//   slot per cycle over the rotating ring. One beat is taken at a time: a
//   new input beat is accepted only once the last result is loaded.
//   The ring is held rotated so that bit 0 is the window start slot.
//   Reset clears the ring, the ping history and the output valid flag; the
//   interval returns to 5. A stalled master keeps the result in its output
//   register while the next input beat is already taken and processed.
// ----------------------------------------------------------------------------
module link_quality_ping_window_core #(
    parameter int WINDOW_SLOTS = lqpw_pkg::SLOTS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lqpw_pkg::BI_W-1:0]           cfg_wr_data,   // beacon_interval
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lqpw_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [31:0] now_seconds
    input  wire logic [0:0]                          s_axis_tuser,  // [0] mode
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [lqpw_pkg::TDATA_OUT_W-1:0]         m_axis_tdata   // [4:0] link_quality
);

    localparam int QW      = $clog2(WINDOW_SLOTS);
    localparam int SW      = $clog2(WINDOW_SLOTS + 2);
    localparam int CW      = $clog2(WINDOW_SLOTS + 1);
    localparam int KW      = $clog2(WINDOW_SLOTS);
    localparam int EXT_W   = (CW > lqpw_pkg::LQ_W) ? CW : lqpw_pkg::LQ_W;
    localparam int OUT_PAD = lqpw_pkg::TDATA_OUT_W - lqpw_pkg::LQ_W;
    localparam int TW      = lqpw_pkg::TIME_W;
    localparam int DW      = lqpw_pkg::DIV_W;
    localparam int BW      = lqpw_pkg::BI_W;

    lqpw_pkg::state_t state_reg, state_next;

    logic                      mode_reg, mode_next;
    logic [TW-1:0]             now_reg, now_next;
    logic [BW-1:0]             bi_reg, bi_next;
    logic [TW-1:0]             last_reg, last_next;
    logic                      seen_reg, seen_next;
    logic [WINDOW_SLOTS-1:0]   ring_reg, ring_next;
    logic [DW-1:0]             div_reg, div_next;
    logic [BW-1:0]             rem_reg, rem_next;
    logic [lqpw_pkg::STEP_W-1:0] step_reg, step_next;
    logic [QW-1:0]             qmod_reg, qmod_next;
    logic [SW-1:0]             qsat_reg, qsat_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic                      out_valid_reg, out_valid_next;
    logic [lqpw_pkg::LQ_W-1:0] out_lq_reg, out_lq_next;

    // Divider and walk helpers
    logic [BW-1:0]   bi_eff;
    logic [BW:0]     div_part;
    logic [BW:0]     div_diff;
    logic            div_ge;
    logic [QW:0]     qm_t;
    logic [SW:0]     qs_t;
    logic [TW-1:0]   last_eff;
    logic [DW-1:0]   elapsed;
    logic            op_backfill;
    logic            op_advance;
    logic            do_rotate;
    logic            slot_in;
    logic            slot_out;
    logic [SW:0]     dist_from_end;
    logic [EXT_W-1:0] cnt_ext;
    logic            can_load;

    assign bi_eff   = (bi_reg == '0) ? BW'(1) : bi_reg;
    assign div_part = {rem_reg, div_reg[DW-1]};
    assign div_diff = div_part - {1'b0, bi_eff};
    assign div_ge   = (div_part >= {1'b0, bi_eff});
    assign qm_t     = {qmod_reg, div_ge};
    assign qs_t     = {qsat_reg, div_ge};

    // The first ping counts from its own time
    assign last_eff = (!mode_reg && !seen_reg) ? now_reg : last_reg;
    assign elapsed  = {1'b0, now_reg} - {1'b0, last_eff};

    assign op_backfill = !mode_reg && (qsat_reg == '0);
    assign op_advance  = !mode_reg && (qsat_reg != '0);
    assign do_rotate   = op_advance && (qmod_reg != '0);

    // Walk visits slot WINDOW_SLOTS-1-k, i.e. from the newest slot back
    assign slot_in       = ring_reg[WINDOW_SLOTS-1];
    assign dist_from_end = (SW+1)'(WINDOW_SLOTS) - (SW+1)'(k_reg);

    always_comb begin
        slot_out = slot_in;
        if (op_backfill) begin
            if (!done_reg && !slot_in) begin
                slot_out = 1'b1;
            end
        end else if (op_advance) begin
            if ((SW+1)'(k_reg) < (SW+1)'(qsat_reg)) begin
                slot_out = (k_reg == '0);
            end
        end else begin
            // Query drops the oldest interval-1 slots, counted from the start
            if (dist_from_end < (SW+1)'(qsat_reg)) begin
                slot_out = 1'b0;
            end
        end
    end

    assign cnt_ext  = EXT_W'(cnt_reg);
    assign can_load = !out_valid_reg || m_axis_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lqpw_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = lqpw_pkg::ST_SUB;
                end
            end
            lqpw_pkg::ST_SUB: begin
                state_next = lqpw_pkg::ST_ADD;
            end
            lqpw_pkg::ST_ADD: begin
                state_next = lqpw_pkg::ST_DIV;
            end
            lqpw_pkg::ST_DIV: begin
                if (step_reg == lqpw_pkg::STEP_W'(DW - 1)) begin
                    state_next = lqpw_pkg::ST_ROT;
                end
            end
            lqpw_pkg::ST_ROT: begin
                if (!do_rotate) begin
                    state_next = lqpw_pkg::ST_WALK;
                end
            end
            lqpw_pkg::ST_WALK: begin
                if (k_reg == KW'(WINDOW_SLOTS - 1)) begin
                    state_next = lqpw_pkg::ST_DONE;
                end
            end
            lqpw_pkg::ST_DONE: begin
                if (can_load) begin
                    state_next = lqpw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lqpw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        mode_next      = mode_reg;
        now_next       = now_reg;
        bi_next        = cfg_wr_en ? cfg_wr_data : bi_reg;
        last_next      = last_reg;
        seen_next      = seen_reg;
        ring_next      = ring_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        qmod_next      = qmod_reg;
        qsat_next      = qsat_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        out_lq_next    = out_lq_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lqpw_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    mode_next = s_axis_tuser[0];
                    now_next  = s_axis_tdata[TW-1:0];
                end
            end
            lqpw_pkg::ST_SUB: begin
                div_next = elapsed;
                if (!mode_reg) begin
                    last_next = now_reg;
                    seen_next = 1'b1;
                end
            end
            lqpw_pkg::ST_ADD: begin
                // Negative elapsed time counts as zero intervals
                div_next  = div_reg[DW-1] ? '0
                          : ({1'b0, div_reg[TW-1:0]} + DW'(bi_eff >> 1));
                rem_next  = '0;
                step_next = '0;
                qmod_next = '0;
                qsat_next = '0;
            end
            lqpw_pkg::ST_DIV: begin
                rem_next  = div_ge ? div_diff[BW-1:0] : div_part[BW-1:0];
                div_next  = {div_reg[DW-2:0], 1'b0};
                step_next = step_reg + lqpw_pkg::STEP_W'(1);
                // Keep the quotient modulo the ring and saturated past it
                qmod_next = (qm_t >= (QW+1)'(WINDOW_SLOTS))
                          ? QW'(qm_t - (QW+1)'(WINDOW_SLOTS)) : qm_t[QW-1:0];
                qsat_next = (qs_t >= (SW+1)'(WINDOW_SLOTS + 1))
                          ? SW'(WINDOW_SLOTS + 1) : qs_t[SW-1:0];
            end
            lqpw_pkg::ST_ROT: begin
                // Advance the window start one slot per cycle
                if (do_rotate) begin
                    ring_next = {ring_reg[0], ring_reg[WINDOW_SLOTS-1:1]};
                    qmod_next = qmod_reg - QW'(1);
                end
                k_next    = '0;
                cnt_next  = '0;
                done_next = 1'b0;
            end
            lqpw_pkg::ST_WALK: begin
                ring_next = {ring_reg[WINDOW_SLOTS-2:0], slot_out};
                k_next    = k_reg + KW'(1);
                cnt_next  = cnt_reg + CW'(slot_out);
                if (op_backfill && !slot_in) begin
                    done_next = 1'b1;
                end
            end
            lqpw_pkg::ST_DONE: begin
                if (can_load) begin
                    out_lq_next    = cnt_ext[lqpw_pkg::LQ_W-1:0];
                    out_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lqpw_pkg::ST_IDLE;
            bi_reg        <= lqpw_pkg::BI_RESET;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            ring_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bi_reg        <= bi_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
            ring_reg      <= ring_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        now_reg    <= now_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        qmod_reg   <= qmod_next;
        qsat_reg   <= qsat_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        done_reg   <= done_next;
        out_lq_reg <= out_lq_next;
    end

    assign s_axis_tready = (state_reg == lqpw_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_lq_reg};

endmodule
`default_nettype wire

@@ rtl/core/lqpw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqpw_checker
// Port-level checks of the link quality estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "link_quality_ping_window_core_assert.svh"

module lqpw_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // A stalled result beat holds
    `LQPW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // One beat in flight: the input closes after a beat is taken
    `LQPW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

    // No result can follow an input beat on the next cycle
    `LQPW_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too early")

    // A new result is loaded only as the block goes idle
    `LQPW_ASSERT_IMPLIES(a_result_at_idle, aclk, aresetn, $rose(m_axis_tvalid), s_axis_tready, "result loaded while busy")

    // Reset empties the output and opens the input
    `LQPW_ASSERT_NEXT_ALWAYS(a_reset_state, aclk, !aresetn, !m_axis_tvalid && s_axis_tready, "bad state after reset")

endmodule

bind link_quality_ping_window_core lqpw_checker u_lqpw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
